FILE: src/sts_pkg.sv
// Shared types, token codes, character codes and keyword tables for the
// source token scanner. Used by sts_core, sts_out_fifo and source_token_scanner.
`default_nettype none

package sts_pkg;

    localparam int OFFSET_BITS_DEFAULT = 24;
    localparam int LINE_BITS_DEFAULT   = 20;

    localparam int KIND_W   = 6;
    localparam int START_W  = 24;
    localparam int LENGTH_W = 16;
    localparam int LINE_W   = 20;

    localparam int NUM_KW    = 16;
    localparam int KW_COLS   = 8;
    localparam int IDLEN_W   = 3;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // Token kinds.
    localparam logic [KIND_W-1:0] TK_LPAREN   = 6'd0;
    localparam logic [KIND_W-1:0] TK_RPAREN   = 6'd1;
    localparam logic [KIND_W-1:0] TK_LBRACE   = 6'd2;
    localparam logic [KIND_W-1:0] TK_RBRACE   = 6'd3;
    localparam logic [KIND_W-1:0] TK_COMMA    = 6'd4;
    localparam logic [KIND_W-1:0] TK_DOT      = 6'd5;
    localparam logic [KIND_W-1:0] TK_MINUS    = 6'd6;
    localparam logic [KIND_W-1:0] TK_PLUS     = 6'd7;
    localparam logic [KIND_W-1:0] TK_SEMI     = 6'd8;
    localparam logic [KIND_W-1:0] TK_SLASH    = 6'd9;
    localparam logic [KIND_W-1:0] TK_STAR     = 6'd10;
    localparam logic [KIND_W-1:0] TK_BANG     = 6'd11;
    localparam logic [KIND_W-1:0] TK_EQUAL    = 6'd13;
    localparam logic [KIND_W-1:0] TK_GREATER  = 6'd15;
    localparam logic [KIND_W-1:0] TK_LESS     = 6'd17;
    localparam logic [KIND_W-1:0] TK_IDENT    = 6'd19;
    localparam logic [KIND_W-1:0] TK_STRING   = 6'd20;
    localparam logic [KIND_W-1:0] TK_NUMBER   = 6'd21;
    localparam logic [KIND_W-1:0] TK_KEYWORD0 = 6'd22;
    localparam logic [KIND_W-1:0] TK_END      = 6'd38;
    localparam logic [KIND_W-1:0] TK_ERROR    = 6'd39;

    // Character codes.
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_DIGIT0     = 8'h30;
    localparam logic [7:0] CH_DIGIT9     = 8'h39;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_UC_A       = 8'h41;
    localparam logic [7:0] CH_UC_Z       = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LC_A       = 8'h61;
    localparam logic [7:0] CH_LC_Z       = 8'h7A;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_OP      = 7'b0000010,
        MODE_COMMENT = 7'b0000100,
        MODE_STRING  = 7'b0001000,
        MODE_IDENT   = 7'b0010000,
        MODE_INT     = 7'b0100000,
        MODE_FRAC    = 7'b1000000
    } scan_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [START_W-1:0]  start;
        logic [LENGTH_W-1:0] length;
        logic [LINE_W-1:0]   line;
        logic                last;
    } token_t;

    // Tokens handed from the scanner to the output queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } push_t;

    // Keyword spelling, one character per column, zero padded.
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_COLS] = '{
        '{"a", "n", "d", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"c", "l", "a", "s", "s", CH_NUL, CH_NUL, CH_NUL},
        '{"e", "l", "s", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"f", "a", "l", "s", "e", CH_NUL, CH_NUL, CH_NUL},
        '{"f", "u", "n", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"f", "o", "r", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"n", "i", "l", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"o", "r", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"p", "r", "i", "n", "t", CH_NUL, CH_NUL, CH_NUL},
        '{"r", "e", "t", "u", "r", "n", CH_NUL, CH_NUL},
        '{"s", "u", "p", "e", "r", CH_NUL, CH_NUL, CH_NUL},
        '{"t", "h", "i", "s", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"t", "r", "u", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"v", "a", "r", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"w", "h", "i", "l", "e", CH_NUL, CH_NUL, CH_NUL}
    };

    localparam logic [IDLEN_W-1:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
        3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
    };

    // Keywords whose character at position pos equals c.
    function automatic logic [NUM_KW-1:0] cand_at(input logic [IDLEN_W-1:0] pos,
                                                   input logic [7:0] c);
        logic [NUM_KW-1:0] m;
        m = '0;
        for (int i = 0; i < NUM_KW; i++) begin
            if (pos != 3'd7 && KW_TEXT[i][pos] == c) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    // The highest-numbered surviving keyword of the right length wins.
    function automatic logic [KIND_W-1:0] ident_kind(input logic [NUM_KW-1:0] cand,
                                                      input logic [IDLEN_W-1:0] idlen);
        logic [KIND_W-1:0] k;
        k = TK_IDENT;
        for (int i = 0; i < NUM_KW; i++) begin
            if (cand[i] && idlen == KW_LEN[i]) begin
                k = TK_KEYWORD0 + KIND_W'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            CH_BANG:    k = TK_BANG;
            CH_EQUAL:   k = TK_EQUAL;
            CH_GREATER: k = TK_GREATER;
            CH_LESS:    k = TK_LESS;
            default:    k = TK_SLASH;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: src/sts_core.sv
// Scanner core: input register, scan state and the per-byte token decode.
// Depends on sts_pkg; feeds sts_out_fifo with up to two tokens per byte.
`default_nettype none

module sts_core import sts_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
    parameter int LINE_BITS   = LINE_BITS_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_code,
    input  wire logic       s_end_mark,
    input  wire logic       room2,
    output push_t           push
);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_char_reg;
    logic                   in_end_reg;

    scan_mode_t             mode_reg, mode_next;
    logic [7:0]             pend_reg, pend_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [LENGTH_W-1:0]    len_reg, len_next;
    logic [NUM_KW-1:0]      cand_reg, cand_next;
    logic [IDLEN_W-1:0]     idlen_reg, idlen_next;

    logic                   fire;
    logic [7:0]             c;
    logic [LENGTH_W-1:0]    len_sat;
    logic                   is_digit, is_alpha;
    logic                   idle_run, line_inc;
    logic                   fl_valid, sg_valid, en_valid;
    logic [KIND_W-1:0]      fl_kind, sg_kind;
    logic [LENGTH_W-1:0]    fl_len;
    logic [31:0]            start_wide, pos_wide, line_wide;
    token_t                 t_fl, t_sg, t_en, t_second;
    logic                   second_valid;
    logic [1:0]             n_tok;

    assign fire    = in_valid_reg && room2;
    assign s_ready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
            in_end_reg  <= s_end_mark;
        end
    end

    assign c        = in_char_reg;
    assign len_sat  = (len_reg == '1) ? len_reg : len_reg + LENGTH_W'(1);
    assign is_digit = c inside {[CH_DIGIT0:CH_DIGIT9]};
    assign is_alpha = c inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z], CH_UNDERSCORE};

    always_comb begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        cand_next  = cand_reg;
        idlen_next = idlen_reg;
        fl_valid   = 1'b0;
        fl_kind    = TK_SLASH;
        fl_len     = LENGTH_W'(1);
        sg_valid   = 1'b0;
        sg_kind    = TK_LPAREN;
        en_valid   = 1'b0;
        idle_run   = 1'b0;
        line_inc   = 1'b0;

        if (in_end_reg) begin
            case (mode_reg)
                MODE_OP: begin
                    fl_valid = 1'b1;
                    fl_kind  = op_kind(pend_reg);
                end
                MODE_IDENT: begin
                    fl_valid = 1'b1;
                    fl_kind  = ident_kind(cand_reg, idlen_reg);
                    fl_len   = len_reg;
                end
                MODE_INT, MODE_FRAC: begin
                    fl_valid = 1'b1;
                    fl_kind  = TK_NUMBER;
                    fl_len   = len_reg;
                end
                MODE_STRING: begin
                    fl_valid = 1'b1;
                    fl_kind  = TK_ERROR;
                    fl_len   = len_reg;
                end
                default: begin
                end
            endcase
            en_valid = 1'b1;
        end else begin
            case (mode_reg)
                MODE_OP: begin
                    if (pend_reg == CH_SLASH) begin
                        if (c == CH_SLASH) begin
                            mode_next = MODE_COMMENT;
                            pend_next = '0;
                        end else begin
                            fl_valid = 1'b1;
                            fl_kind  = TK_SLASH;
                            idle_run = 1'b1;
                        end
                    end else if (c == CH_EQUAL) begin
                        fl_valid  = 1'b1;
                        fl_kind   = op_kind(pend_reg) + KIND_W'(1);
                        fl_len    = LENGTH_W'(2);
                        mode_next = MODE_IDLE;
                        pend_next = '0;
                    end else begin
                        fl_valid = 1'b1;
                        fl_kind  = op_kind(pend_reg);
                        idle_run = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_NEWLINE) begin
                        mode_next = MODE_IDLE;
                        pend_next = '0;
                        line_inc  = 1'b1;
                    end
                end
                MODE_STRING: begin
                    len_next = len_sat;
                    if (c == CH_NEWLINE) begin
                        line_inc = 1'b1;
                    end
                    if (c == CH_QUOTE) begin
                        fl_valid  = 1'b1;
                        fl_kind   = TK_STRING;
                        fl_len    = len_sat;
                        mode_next = MODE_IDLE;
                        pend_next = '0;
                    end
                end
                MODE_IDENT: begin
                    if (is_alpha || is_digit) begin
                        len_next = len_sat;
                        if (idlen_reg != '1) begin
                            cand_next  = cand_reg & cand_at(idlen_reg, c);
                            idlen_next = idlen_reg + IDLEN_W'(1);
                        end
                    end else begin
                        fl_valid = 1'b1;
                        fl_kind  = ident_kind(cand_reg, idlen_reg);
                        fl_len   = len_reg;
                        idle_run = 1'b1;
                    end
                end
                MODE_INT, MODE_FRAC: begin
                    if (is_digit) begin
                        len_next = len_sat;
                    end else if (c == CH_DOT && mode_reg == MODE_INT) begin
                        len_next  = len_sat;
                        mode_next = MODE_FRAC;
                    end else begin
                        fl_valid = 1'b1;
                        fl_kind  = TK_NUMBER;
                        fl_len   = len_reg;
                        idle_run = 1'b1;
                    end
                end
                default: begin
                    idle_run = 1'b1;
                end
            endcase

            // The byte that closed a token, or any byte seen while idle,
            // is classified as the start of something new.
            if (idle_run) begin
                mode_next = MODE_IDLE;
                pend_next = '0;
                sg_valid  = 1'b1;
                case (c)
                    CH_LPAREN:  sg_kind = TK_LPAREN;
                    CH_RPAREN:  sg_kind = TK_RPAREN;
                    CH_LBRACE:  sg_kind = TK_LBRACE;
                    CH_RBRACE:  sg_kind = TK_RBRACE;
                    CH_COMMA:   sg_kind = TK_COMMA;
                    CH_DOT:     sg_kind = TK_DOT;
                    CH_MINUS:   sg_kind = TK_MINUS;
                    CH_PLUS:    sg_kind = TK_PLUS;
                    CH_SEMI:    sg_kind = TK_SEMI;
                    CH_STAR:    sg_kind = TK_STAR;
                    default:    sg_valid = 1'b0;
                endcase
                if (c inside {CH_BANG, CH_EQUAL, CH_LESS, CH_GREATER, CH_SLASH}) begin
                    mode_next  = MODE_OP;
                    pend_next  = c;
                    start_next = pos_reg;
                end else if (c == CH_QUOTE) begin
                    mode_next  = MODE_STRING;
                    start_next = pos_reg;
                    len_next   = LENGTH_W'(1);
                end else if (c == CH_NEWLINE) begin
                    line_inc = 1'b1;
                end else if (is_digit) begin
                    mode_next  = MODE_INT;
                    start_next = pos_reg;
                    len_next   = LENGTH_W'(1);
                end else if (is_alpha) begin
                    mode_next  = MODE_IDENT;
                    start_next = pos_reg;
                    len_next   = LENGTH_W'(1);
                    idlen_next = IDLEN_W'(1);
                    cand_next  = cand_at('0, c);
                end
            end

            if (pos_reg != '1) begin
                pos_next = pos_reg + OFFSET_BITS'(1);
            end
        end

        line_next = line_reg;
        if (line_inc && line_reg != '1) begin
            line_next = line_reg + LINE_BITS'(1);
        end

        // End of source returns everything to its reset value.
        if (in_end_reg) begin
            mode_next  = MODE_IDLE;
            pend_next  = '0;
            start_next = '0;
            pos_next   = '0;
            line_next  = LINE_BITS'(1);
            len_next   = '0;
            cand_next  = '1;
            idlen_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pend_reg  <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
            len_reg   <= '0;
            cand_reg  <= '1;
            idlen_reg <= '0;
        end else if (fire) begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            len_reg   <= len_next;
            cand_reg  <= cand_next;
            idlen_reg <= idlen_next;
        end
    end

    // Tokens carry the line count from before this byte's update.
    assign start_wide = 32'(start_reg);
    assign pos_wide   = 32'(pos_reg);
    assign line_wide  = 32'(line_reg);

    always_comb begin
        t_fl.kind   = fl_kind;
        t_fl.start  = start_wide[START_W-1:0];
        t_fl.length = fl_len;
        t_fl.line   = line_wide[LINE_W-1:0];
        t_fl.last   = 1'b0;

        t_sg.kind   = sg_kind;
        t_sg.start  = pos_wide[START_W-1:0];
        t_sg.length = LENGTH_W'(1);
        t_sg.line   = line_wide[LINE_W-1:0];
        t_sg.last   = 1'b1;

        t_en.kind   = TK_END;
        t_en.start  = pos_wide[START_W-1:0];
        t_en.length = '0;
        t_en.line   = line_wide[LINE_W-1:0];
        t_en.last   = 1'b1;

        t_second     = sg_valid ? t_sg : t_en;
        second_valid = sg_valid || en_valid;

        if (fl_valid) begin
            push.tok0      = t_fl;
            push.tok0.last = !second_valid;
            push.tok1      = t_second;
            n_tok          = second_valid ? 2'd2 : 2'd1;
        end else begin
            push.tok0 = t_second;
            push.tok1 = t_second;
            n_tok     = second_valid ? 2'd1 : 2'd0;
        end
        push.count = fire ? n_tok : 2'd0;
    end

endmodule

`default_nettype wire

FILE: src/sts_out_fifo.sv
// Output queue of finished tokens, taking up to two per cycle and giving
// one per cycle while m_ready is high. Depends on sts_pkg.
`default_nettype none

module sts_out_fifo import sts_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire push_t push,
    output logic      room2,
    output logic      m_valid,
    input  wire logic m_ready,
    output token_t    m_token
);

    token_t                mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0]   count_reg, count_next;
    logic [OQ_CNT_W-1:0]   occ;
    logic                  pop;

    assign m_valid = (count_reg != '0);
    assign pop     = m_valid && m_ready;
    assign m_token = mem[rd_ptr_reg];

    // Two free slots are needed since one byte can close two tokens.
    assign occ   = count_reg - OQ_CNT_W'(pop);
    assign room2 = (occ <= OQ_CNT_W'(OQ_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + OQ_PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + OQ_PTR_W'(pop);
    assign count_next  = occ + OQ_CNT_W'(push.count);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.tok0;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + OQ_PTR_W'(1)] <= push.tok1;
        end
    end

endmodule

`default_nettype wire

FILE: src/source_token_scanner.sv
// Source token scanner, the top level: an input register and scanner core
// (sts_core) feeding a four-entry token queue (sts_out_fifo). Uses sts_pkg.
//
// One source byte (or an end-of-source marker) is taken per transaction and
// turned into zero, one or two tokens. The block accepts a new byte every
// cycle while the queue has room; the output queue hands out one token per
// cycle while m_ready is high, so a byte that closes two tokens (for example
// an identifier followed by a semicolon, or the end marker after a pending
// token) takes two output transfers, and input is held off whenever fewer
// than two queue slots will be free. A byte is held in the input register
// and its tokens are then written into the token queue, which raises m_valid.
// Tokens that end only when the next byte is seen (the operators !, =, <, >
// and /, identifiers, keywords, numbers) are emitted with that byte or with
// the end marker. After the end token the scanner restarts at offset 0,
// line 1.
`default_nettype none

module source_token_scanner import sts_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
    parameter int LINE_BITS   = LINE_BITS_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_char_code,
    input  wire logic                s_end_mark,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [KIND_W-1:0]        m_token_kind,
    output logic [START_W-1:0]       m_token_start,
    output logic [LENGTH_W-1:0]      m_token_length,
    output logic [LINE_W-1:0]        m_token_line,
    output logic                     m_last_of_run
);

    push_t  push;
    logic   room2;
    token_t m_token;

    sts_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_end_mark  (s_end_mark),
        .room2       (room2),
        .push        (push)
    );

    sts_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room2   (room2),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_token (m_token)
    );

    assign m_token_kind   = m_token.kind;
    assign m_token_start  = m_token.start;
    assign m_token_length = m_token.length;
    assign m_token_line   = m_token.line;
    assign m_last_of_run  = m_token.last;

endmodule

`default_nettype wire
